[hdl/sha256_stream_hasher_defines.svh]
// Assertion macros shared by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S256H_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s256h same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define S256H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s256h next-cycle check failed");

`endif

[hdl/s256h_pkg.sv]
// Shared types, commands and constants of the SHA-256 stream hasher.
package s256h_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_LENGTH,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_EXTRA,
    PH_FINAL
  } phase_e;

  typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

  typedef struct packed {
    logic       write_byte;
    logic [7:0] data;
    logic       mark;
    logic       clear_all;
    logic       write_len;
    logic       load;
    logic       round;
    logic [5:0] rnd;
    logic       update;
    logic       init;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } dp_status_t;

endpackage

[hdl/s256h_dp.sv]
// Datapath: block buffer and message schedule window, round unit, chain value and length.
module s256h_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  s256h_pkg::dp_cmd_t cmd_i,
  output logic [5:0]         fill_o,
  output s256h_pkg::digest_t digest_o
);
  import s256h_pkg::*;

  logic [31:0] w_q [BLOCK_WORDS];
  logic [31:0] w_d [BLOCK_WORDS];
  logic [31:0] v_q [DIGEST_WORDS];
  logic [31:0] v_d [DIGEST_WORDS];
  logic [31:0] chain_q [DIGEST_WORDS];
  logic [31:0] chain_d [DIGEST_WORDS];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic [63:0] bit_len;
  logic [1:0]  lane;
  logic [31:0] w_next, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign bit_len = {len_q, 3'b000};
  assign lane    = 2'd3 - fill_q[1:0];

  // Next schedule word from the sliding window W[t..t+15].
  assign w_next = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
                + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];

  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[cmd_i.rnd] + w_q[0];
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    w_d = w_q;
    if (cmd_i.write_byte) begin
      w_d[fill_q[5:2]][{lane, 3'b000} +: 8] = cmd_i.data;
    end
    if (cmd_i.mark) begin
      // Padding marker at the fill position, zeros in every byte after it.
      for (int i = 0; i < 64; i++) begin
        if (6'(i) == fill_q) begin
          w_d[i >> 2][8 * (3 - (i & 3)) +: 8] = PAD_BYTE;
        end else if (6'(i) > fill_q) begin
          w_d[i >> 2][8 * (3 - (i & 3)) +: 8] = 8'h00;
        end
      end
    end
    if (cmd_i.clear_all) begin
      for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
        w_d[i] = '0;
      end
    end
    if (cmd_i.write_len) begin
      w_d[BLOCK_WORDS-2] = bit_len[63:32];
      w_d[BLOCK_WORDS-1] = bit_len[31:0];
    end
    if (cmd_i.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[BLOCK_WORDS-1] = w_next;
    end
  end

  always_comb begin
    v_d = v_q;
    if (cmd_i.load) begin
      v_d = chain_q;
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_comb begin
    chain_d = chain_q;
    fill_d  = fill_q;
    len_d   = len_q;
    if (cmd_i.write_byte) begin
      fill_d = fill_q + 6'd1;
      len_d  = len_q + 61'd1;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_d[i] = chain_q[i] + v_q[i];
      end
    end
    if (cmd_i.init) begin
      chain_d = INIT_HASH;
      fill_d  = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= INIT_HASH;
      fill_q  <= '0;
      len_q   <= '0;
    end else begin
      chain_q <= chain_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      digest_o[i] = chain_q[i];
    end
  end

  assign fill_o = fill_q;

endmodule

[hdl/s256h_obuf.sv]
// Output buffer that streams the eight digest words while the core goes on.
module s256h_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  s256h_pkg::digest_t digest_i,
  output logic               busy_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,
  output logic               m_axis_tlast
);
  import s256h_pkg::*;

  digest_t    buf_q, buf_d;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       last;

  assign last = (idx_q == 3'(DIGEST_WORDS - 1));

  always_comb begin
    buf_d  = buf_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      buf_d  = digest_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && m_axis_tready) begin
      buf_d = buf_q >> 32;
      idx_d = idx_q + 3'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign busy_o        = busy_q;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {5'b0, idx_q, buf_q[0]};
  assign m_axis_tlast  = last;

endmodule

[hdl/s256h_ctrl.sv]
// Controller: sequences byte intake, padding, compression rounds and digest handover.
module s256h_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  s256h_pkg::dp_status_t status_i,
  output s256h_pkg::dp_cmd_t    cmd_o
);
  import s256h_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        end_q, end_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    end_d   = end_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    cmd_o.data = s_axis_tdata;
    cmd_o.rnd  = rnd_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.write_byte = s_axis_tuser;
          if (s_axis_tuser && (status_i.fill == 6'd63)) begin
            phase_d = PH_DATA;
            end_d   = s_axis_tlast;
            state_d = ST_LOAD;
          end else if (s_axis_tlast) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
        end_d      = 1'b0;
        if (status_i.fill >= 6'd56) begin
          phase_d = PH_EXTRA;
          state_d = ST_LOAD;
        end else begin
          phase_d = PH_DATA;
          state_d = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        cmd_o.write_len = 1'b1;
        cmd_o.clear_all = (phase_q == PH_EXTRA);
        phase_d = PH_FINAL;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        rnd_d      = '0;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'(ROUNDS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        case (phase_q)
          PH_EXTRA: state_d = ST_LENGTH;
          PH_FINAL: state_d = ST_DONE;
          default:  state_d = end_q ? ST_MARK : ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.init = 1'b1;
          phase_d    = PH_DATA;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DATA;
      end_q   <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      end_q   <= end_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

[hdl/sha256_stream_hasher.sv]
// A byte item is taken only while the controller is idle; a byte that fills a block starts its compression.
// A final item starts padding, with an extra block when the length does not fit in the current one.
// The one-round-per-cycle compression loop sets the pace; no byte is taken while a block is compressed.
// The eight digest words then leave one per cycle from an output buffer as the sink takes them.
// Reset is asynchronous and active low; it restores the standard initial hash values,
// empties the block and clears the length. No clearing pass is needed after reset.
`include "sha256_stream_hasher_defines.svh"

// Top level of the SHA-256 stream hasher: controller, datapath and output buffer.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] byte_valid
  input  logic        s_axis_tlast,  // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast   // last_word
);
  import s256h_pkg::*;

  // The controller steers the datapath through a one-hot-ish command struct and reads
  // back the block fill level and whether the output buffer is still draining.
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [5:0] fill;
  digest_t    digest;
  logic       out_busy;

  assign status.fill     = fill;
  assign status.out_busy = out_busy;

  s256h_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // The datapath holds the 16-word window that serves first as the block buffer and
  // then as the message schedule, so compressing a block consumes its contents.
  s256h_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .fill_o   (fill),
    .digest_o (digest)
  );

  // The finished digest is copied out here, so the next message may start streaming in
  // while the sink is still taking the words of the previous one.
  s256h_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (cmd.emit),
    .digest_i      (digest),
    .busy_o        (out_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A digest is never copied over one that has not fully left.
  `S256H_ASSERT_SAME(a_emit_free, clk_i, rst_ni, cmd.emit, !out_busy)
  // A final item leads to padding, after the compression of a block that it fills, so intake stops on the next cycle.
  `S256H_ASSERT_NEXT(a_end_stalls, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // The last word of a digest carries the top word index.
  `S256H_ASSERT_SAME(a_last_index, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tlast, m_axis_tdata[34:32] == 3'd7)
  // Once the last word is taken the buffer is empty on the next cycle.
  `S256H_ASSERT_NEXT(a_drain, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule
